// ===== design/tsp_pkg.sv =====
// Shared types, constants and pattern tables for the triangle split pattern block.
`default_nettype none

package tsp_pkg;

  localparam int VERTEX_BITS = 24;
  localparam int LENGTH_BITS = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [VERTEX_BITS-1:0] vert_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef struct packed {
    vert_t vert_a;
    vert_t vert_b;
    vert_t vert_c;
    vert_t mid_ab;
    vert_t mid_bc;
    vert_t mid_ca;
    logic  split_ab;
    logic  split_bc;
    logic  split_ca;
    len_t  len_ab;
    len_t  len_bc;
    len_t  len_ca;
  } tsp_in_t;

  typedef struct packed {
    vert_t corner_0;
    vert_t corner_1;
    vert_t corner_2;
    logic  was_split;
    logic  is_last;
  } tsp_out_t;

  // Split sets, written as {ab, bc, ca}.
  localparam logic [2:0] SPLIT_ALL   = 3'b111;
  localparam logic [2:0] SPLIT_AB_BC = 3'b110;
  localparam logic [2:0] SPLIT_AB_CA = 3'b101;
  localparam logic [2:0] SPLIT_BC_CA = 3'b011;
  localparam logic [2:0] SPLIT_AB    = 3'b100;
  localparam logic [2:0] SPLIT_BC    = 3'b010;
  localparam logic [2:0] SPLIT_CA    = 3'b001;

  typedef enum logic [3:0] {
    PAT_NONE,
    PAT_AB,
    PAT_BC,
    PAT_CA,
    PAT_AB_BC,
    PAT_AB_CA,
    PAT_BC_CA,
    PAT_ALL_AB,
    PAT_ALL_BC,
    PAT_ALL_CA
  } pat_t;

  typedef enum logic [2:0] {
    SL_A,
    SL_B,
    SL_C,
    SL_MAB,
    SL_MBC,
    SL_MCA
  } slot_t;

  typedef struct packed {
    slot_t s0;
    slot_t s1;
    slot_t s2;
  } tri_slots_t;

  typedef logic [1:0] child_idx_t;

  // One classified parent as it waits in the queue.
  typedef struct packed {
    pat_t  pat;
    vert_t a;
    vert_t b;
    vert_t c;
    vert_t mab;
    vert_t mbc;
    vert_t mca;
  } tsp_entry_t;

  function automatic child_idx_t last_index(pat_t p);
    child_idx_t n;
    unique case (p)
      PAT_NONE:                           n = 2'd0;
      PAT_AB, PAT_BC, PAT_CA:             n = 2'd1;
      PAT_AB_BC, PAT_AB_CA, PAT_BC_CA:    n = 2'd2;
      PAT_ALL_AB, PAT_ALL_BC, PAT_ALL_CA: n = 2'd3;
      default:                            n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic tri_slots_t child_slots(pat_t p, child_idx_t k);
    tri_slots_t row [4];
    row = '{'{SL_A, SL_B, SL_C}, '{SL_A, SL_B, SL_C},
            '{SL_A, SL_B, SL_C}, '{SL_A, SL_B, SL_C}};
    unique case (p)
      PAT_NONE:  row[0] = '{SL_A, SL_B, SL_C};
      PAT_AB: begin
        row[0] = '{SL_A,   SL_MAB, SL_C};
        row[1] = '{SL_MAB, SL_B,   SL_C};
      end
      PAT_BC: begin
        row[0] = '{SL_A,   SL_B, SL_MBC};
        row[1] = '{SL_MBC, SL_C, SL_A};
      end
      PAT_CA: begin
        row[0] = '{SL_A,   SL_B, SL_MCA};
        row[1] = '{SL_MCA, SL_B, SL_C};
      end
      PAT_AB_BC: begin
        row[0] = '{SL_A,   SL_MAB, SL_MBC};
        row[1] = '{SL_MAB, SL_B,   SL_MBC};
        row[2] = '{SL_A,   SL_MBC, SL_C};
      end
      PAT_AB_CA: begin
        row[0] = '{SL_A,   SL_MAB, SL_MCA};
        row[1] = '{SL_MAB, SL_B,   SL_MCA};
        row[2] = '{SL_MCA, SL_B,   SL_C};
      end
      PAT_BC_CA: begin
        row[0] = '{SL_A,   SL_B, SL_MCA};
        row[1] = '{SL_B,   SL_MBC, SL_MCA};
        row[2] = '{SL_MBC, SL_C, SL_MCA};
      end
      PAT_ALL_AB: begin
        row[0] = '{SL_A,   SL_MAB, SL_MCA};
        row[1] = '{SL_MAB, SL_MBC, SL_C};
        row[2] = '{SL_MAB, SL_B,   SL_MBC};
        row[3] = '{SL_MAB, SL_C,   SL_MCA};
      end
      PAT_ALL_BC: begin
        row[0] = '{SL_MAB, SL_B,   SL_MBC};
        row[1] = '{SL_A,   SL_MAB, SL_MBC};
        row[2] = '{SL_MCA, SL_A,   SL_MBC};
        row[3] = '{SL_C,   SL_MCA, SL_MBC};
      end
      PAT_ALL_CA: begin
        row[0] = '{SL_A,   SL_MAB, SL_MCA};
        row[1] = '{SL_MAB, SL_B,   SL_MCA};
        row[2] = '{SL_B,   SL_MBC, SL_MCA};
        row[3] = '{SL_MBC, SL_C,   SL_MCA};
      end
      default: row[0] = '{SL_A, SL_B, SL_C};
    endcase
    return row[k];
  endfunction

  function automatic vert_t pick_vert(tsp_entry_t e, slot_t s);
    vert_t v;
    unique case (s)
      SL_A:    v = e.a;
      SL_B:    v = e.b;
      SL_C:    v = e.c;
      SL_MAB:  v = e.mab;
      SL_MBC:  v = e.mbc;
      SL_MCA:  v = e.mca;
      default: v = e.a;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/tsp_front.sv =====
// Front end: accepts a parent triangle, classifies its split pattern and registers it.
`default_nettype none

module tsp_front
  import tsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tsp_in_t    in_data,
  output logic            push_valid,
  input  wire logic       push_ready,
  output tsp_entry_t      push_data
);

  logic       st_valid_r;
  logic       st_valid_nxt;
  tsp_entry_t st_data_r;
  tsp_entry_t st_data_nxt;
  logic [2:0] sel;
  logic       ab_max;
  logic       bc_max;
  pat_t       pat;
  logic       take;

  always_comb begin
    sel    = {in_data.split_ab, in_data.split_bc, in_data.split_ca};
    ab_max = (in_data.len_ab >= in_data.len_bc) && (in_data.len_ab >= in_data.len_ca);
    bc_max = (in_data.len_bc >= in_data.len_ab) && (in_data.len_bc >= in_data.len_ca);
    unique case (sel)
      SPLIT_ALL: begin
        // The longest edge picks the layout; ab wins ties, then bc.
        priority if (ab_max) begin
          pat = PAT_ALL_AB;
        end else if (bc_max) begin
          pat = PAT_ALL_BC;
        end else begin
          pat = PAT_ALL_CA;
        end
      end
      SPLIT_AB_BC: pat = PAT_AB_BC;
      SPLIT_AB_CA: pat = PAT_AB_CA;
      SPLIT_BC_CA: pat = PAT_BC_CA;
      SPLIT_AB:    pat = PAT_AB;
      SPLIT_BC:    pat = PAT_BC;
      SPLIT_CA:    pat = PAT_CA;
      default:     pat = PAT_NONE;
    endcase
  end

  assign in_ready = !st_valid_r || push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (take) begin
      st_valid_nxt = 1'b1;
    end else if (push_ready) begin
      st_valid_nxt = 1'b0;
    end
    st_data_nxt = st_data_r;
    if (take) begin
      st_data_nxt = '{pat: pat,
                      a:   in_data.vert_a,
                      b:   in_data.vert_b,
                      c:   in_data.vert_c,
                      mab: in_data.mid_ab,
                      mbc: in_data.mid_bc,
                      mca: in_data.mid_ca};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_data_r <= st_data_nxt;
  end

  assign push_valid = st_valid_r;
  assign push_data  = st_data_r;

endmodule

`default_nettype wire

// ===== design/tsp_queue.sv =====
// Short queue of classified parents between the front end and the back end.
`default_nettype none

module tsp_queue
  import tsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire tsp_entry_t  push_data,
  output logic             head_valid,
  input  wire logic        pop,
  output tsp_entry_t       head_data
);

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);

  tsp_entry_t              store_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]     wr_ptr_r;
  logic [PTR_BITS-1:0]     wr_ptr_nxt;
  logic [PTR_BITS-1:0]     rd_ptr_r;
  logic [PTR_BITS-1:0]     rd_ptr_nxt;
  logic [COUNT_BITS-1:0]   count_r;
  logic [COUNT_BITS-1:0]   count_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count_r != FULL_COUNT);
  assign head_valid = (count_r != '0);
  assign head_data  = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/tsp_back.sv =====
// Back end: walks the children of the queue head, one result word per cycle while out_ready is high.
`default_nettype none

module tsp_back
  import tsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire tsp_entry_t  head_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tsp_out_t         out_data
);

  logic       out_valid_r;
  logic       out_valid_nxt;
  tsp_out_t   out_data_r;
  tsp_out_t   out_data_nxt;
  child_idx_t idx_r;
  child_idx_t idx_nxt;
  child_idx_t last_idx;
  tri_slots_t slots;
  tsp_out_t   child;
  logic       load;

  always_comb begin
    last_idx        = last_index(head_data.pat);
    slots           = child_slots(head_data.pat, idx_r);
    child.corner_0  = pick_vert(head_data, slots.s0);
    child.corner_1  = pick_vert(head_data, slots.s1);
    child.corner_2  = pick_vert(head_data, slots.s2);
    child.was_split = (last_idx != '0);
    child.is_last   = (idx_r == last_idx);
  end

  // The output register refills in the same cycle that its word is taken.
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && child.is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = child;
      idx_nxt       = child.is_last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/triangle_split_pattern.sv =====
// Top level of the triangle split pattern block: front end, queue and back end.
//
//  Channel   Ports                          Word
//  input     in_valid  in_ready  in_data    one parent triangle (tsp_in_t)
//  output    out_valid out_ready out_data   one child triangle (tsp_out_t)
//
// A parent gives 1 to 4 child words, 4 when all edges split; the back end sends
// one word per cycle while out_ready is high. After its parent is accepted, the
// first child word reaches the output through the front register, the queue and
// the output register.
// Reset is synchronous: it empties the front register, the queue and the
// output register and restarts the child count; no clearing pass is needed.
// While out_ready is low the output word holds, the queue fills, and in_ready
// drops once the front register can no longer move on.
`default_nettype none

module triangle_split_pattern
  import tsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tsp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tsp_out_t      out_data
);

  logic       push_valid;
  logic       push_ready;
  tsp_entry_t push_data;
  logic       head_valid;
  tsp_entry_t head_data;
  logic       pop;

  tsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  tsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== design/tsp_checker.sv =====
// Port-level assertions for the triangle split pattern block, bound to the top level.
`default_nettype none

module tsp_checker
  import tsp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire tsp_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire tsp_out_t out_data
);

  // A waiting input word stays and does not change.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word dropped or changed while waiting");

  // A stalled result word stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // Nothing leaves in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // A parent that was not split has a single child, which is its last.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.was_split |-> out_data.is_last)
    else $error("unsplit parent gave a child that is not last");

  // The siblings of a split parent follow without a gap.
  a_siblings_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.is_last |=> out_valid && out_data.was_split)
    else $error("sibling word missing after a child that is not last");

endmodule

bind triangle_split_pattern tsp_checker u_tsp_checker (.*);

`default_nettype wire

// ===== test/tsp_checker.sv =====
// Checker for the triangle split pattern block: predicts child words and compares them.
module tsp_scoreboard
  import tsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  tsp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  tsp_out_t out_data,
  output int       errors,
  output int       pending,
  output int       checked
);

  tsp_out_t children_due [$];

  // Works out the child triangles of one parent, in emission order.
  function automatic void expand_parent(tsp_in_t p);
    logic [2:0] edges;
    vert_t      kid [4][3];
    int         n;
    tsp_out_t   w;
    edges = {p.split_ab, p.split_bc, p.split_ca};
    n = 1;
    kid[0] = '{p.vert_a, p.vert_b, p.vert_c};
    case (edges)
      SPLIT_ALL: begin
        n = 4;
        if (p.len_ab >= p.len_bc && p.len_ab >= p.len_ca) begin
          kid[0] = '{p.vert_a, p.mid_ab, p.mid_ca};
          kid[1] = '{p.mid_ab, p.mid_bc, p.vert_c};
          kid[2] = '{p.mid_ab, p.vert_b, p.mid_bc};
          kid[3] = '{p.mid_ab, p.vert_c, p.mid_ca};
        end else if (p.len_bc >= p.len_ca) begin
          kid[0] = '{p.mid_ab, p.vert_b, p.mid_bc};
          kid[1] = '{p.vert_a, p.mid_ab, p.mid_bc};
          kid[2] = '{p.mid_ca, p.vert_a, p.mid_bc};
          kid[3] = '{p.vert_c, p.mid_ca, p.mid_bc};
        end else begin
          kid[0] = '{p.vert_a, p.mid_ab, p.mid_ca};
          kid[1] = '{p.mid_ab, p.vert_b, p.mid_ca};
          kid[2] = '{p.vert_b, p.mid_bc, p.mid_ca};
          kid[3] = '{p.mid_bc, p.vert_c, p.mid_ca};
        end
      end
      SPLIT_AB_BC: begin
        n = 3;
        kid[0] = '{p.vert_a, p.mid_ab, p.mid_bc};
        kid[1] = '{p.mid_ab, p.vert_b, p.mid_bc};
        kid[2] = '{p.vert_a, p.mid_bc, p.vert_c};
      end
      SPLIT_AB_CA: begin
        n = 3;
        kid[0] = '{p.vert_a, p.mid_ab, p.mid_ca};
        kid[1] = '{p.mid_ab, p.vert_b, p.mid_ca};
        kid[2] = '{p.mid_ca, p.vert_b, p.vert_c};
      end
      SPLIT_BC_CA: begin
        n = 3;
        kid[0] = '{p.vert_a, p.vert_b, p.mid_ca};
        kid[1] = '{p.vert_b, p.mid_bc, p.mid_ca};
        kid[2] = '{p.mid_bc, p.vert_c, p.mid_ca};
      end
      SPLIT_AB: begin
        n = 2;
        kid[0] = '{p.vert_a, p.mid_ab, p.vert_c};
        kid[1] = '{p.mid_ab, p.vert_b, p.vert_c};
      end
      SPLIT_BC: begin
        n = 2;
        kid[0] = '{p.vert_a, p.vert_b, p.mid_bc};
        kid[1] = '{p.mid_bc, p.vert_c, p.vert_a};
      end
      SPLIT_CA: begin
        n = 2;
        kid[0] = '{p.vert_a, p.vert_b, p.mid_ca};
        kid[1] = '{p.mid_ca, p.vert_b, p.vert_c};
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      w.corner_0  = kid[k][0];
      w.corner_1  = kid[k][1];
      w.corner_2  = kid[k][2];
      w.was_split = (n > 1);
      w.is_last   = (k == n - 1);
      children_due = {children_due, w};
    end
  endfunction

  always @(posedge clk) begin
    tsp_out_t want;
    if (!rst_n) begin
      errors  = 0;
      checked = 0;
      children_due.delete();
    end else begin
      if (in_valid && in_ready)
        expand_parent(in_data);
      if (out_valid && out_ready) begin
        checked++;
        if (children_due.size() == 0) begin
          $error("child word %h arrived with no parent waiting", out_data);
          errors++;
        end else begin
          want = children_due.pop_front();
          if (out_data.corner_0 !== want.corner_0) begin
            $error("corner_0: expected %h, got %h", want.corner_0, out_data.corner_0);
            errors++;
          end
          if (out_data.corner_1 !== want.corner_1) begin
            $error("corner_1: expected %h, got %h", want.corner_1, out_data.corner_1);
            errors++;
          end
          if (out_data.corner_2 !== want.corner_2) begin
            $error("corner_2: expected %h, got %h", want.corner_2, out_data.corner_2);
            errors++;
          end
          if (out_data.was_split !== want.was_split) begin
            $error("was_split: expected %b, got %b", want.was_split, out_data.was_split);
            errors++;
          end
          if (out_data.is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, out_data.is_last);
            errors++;
          end
        end
      end
    end
    pending = children_due.size();
  end

endmodule

// ===== test/tb_triangle_split_pattern.sv =====
// Testbench top for the triangle split pattern block: stimulus, clock, reset and verdict.
module tb_triangle_split_pattern;
  import tsp_pkg::*;

  localparam int RANDOM_PARENTS = 350;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tsp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tsp_out_t out_data;

  int errors;
  int pending;
  int checked;
  int cycles       = 0;
  int parents_sent = 0;
  int full_splits  = 0;
  bit gaps_on      = 1'b1;

  triangle_split_pattern u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  tsp_scoreboard u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d child words outstanding.", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls at random, except during the stretch with gaps switched off.
  always @(negedge clk) begin
    out_ready = !(gaps_on && $urandom_range(99) < 34);
  end

  function automatic vert_t any_index();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return vert_t'($urandom());
    endcase
  endfunction

  // Small values make equal lengths common, so the tie rules get exercised.
  function automatic len_t any_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return len_t'($urandom_range(3));
      default: return len_t'($urandom());
    endcase
  endfunction

  function automatic tsp_in_t any_parent();
    tsp_in_t p;
    p.vert_a = any_index();
    p.vert_b = any_index();
    p.vert_c = any_index();
    p.mid_ab = any_index();
    p.mid_bc = any_index();
    p.mid_ca = any_index();
    // At least half of the parents are fully split, since that is where the layout choice lives.
    if ($urandom_range(1))
      {p.split_ab, p.split_bc, p.split_ca} = SPLIT_ALL;
    else
      {p.split_ab, p.split_bc, p.split_ca} = 3'($urandom_range(7));
    p.len_ab = any_length();
    p.len_bc = any_length();
    p.len_ca = any_length();
    return p;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance of the word.
  task automatic send_parent(input tsp_in_t p);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    parents_sent++;
    if ({p.split_ab, p.split_bc, p.split_ca} == SPLIT_ALL)
      full_splits++;
    @(negedge clk);
  endtask

  task automatic send_full_split(input len_t lab, input len_t lbc, input len_t lca);
    tsp_in_t p;
    p = any_parent();
    {p.split_ab, p.split_bc, p.split_ca} = SPLIT_ALL;
    p.len_ab = lab;
    p.len_bc = lbc;
    p.len_ca = lca;
    send_parent(p);
  endtask

  initial begin
    tsp_in_t p;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Every split set once, then the corner values at their extremes.
    for (int s = 0; s < 8; s++) begin
      p = any_parent();
      {p.split_ab, p.split_bc, p.split_ca} = 3'(s);
      send_parent(p);
    end
    p = '0;
    {p.split_ab, p.split_bc, p.split_ca} = SPLIT_ALL;
    send_parent(p);
    p = '1;
    send_parent(p);
    p = '1;
    {p.split_ab, p.split_bc, p.split_ca} = '0;
    send_parent(p);

    // Longest-edge choice, including every kind of tie.
    send_full_split(32'd9, 32'd5, 32'd7);
    send_full_split(32'd5, 32'd9, 32'd7);
    send_full_split(32'd5, 32'd7, 32'd9);
    send_full_split(32'd4, 32'd4, 32'd4);
    send_full_split(32'd6, 32'd6, 32'd2);
    send_full_split(32'd6, 32'd2, 32'd6);
    send_full_split(32'd2, 32'd6, 32'd6);
    send_full_split('0, '0, '1);
    send_full_split('1, '0, '1);

    for (int i = 0; i < RANDOM_PARENTS; i++) begin
      gaps_on = !(i >= 120 && i < 220);
      send_parent(any_parent());
    end
    gaps_on  = 1'b1;
    in_valid = 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d parent triangles (%0d fully split); checked %0d child words.",
             parents_sent, full_splits, checked);
    $display("Covered every split set, all three longest-edge layouts and their ties.");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
